@@ rtl/awr_pkg.sv @@
package awr_pkg;

  localparam int unsigned TARGET_CELLS_DEF = 1024;
  localparam int unsigned SOURCE_CELLS_DEF = 256;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TIX_W  = 10;
  localparam int unsigned SIX_W  = 8;
  localparam int unsigned WSUM_W = 40;
  localparam int unsigned ASUM_W = 24;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned IDX_W  = 17;

  localparam logic [VAL_W-1:0] ONE_Q15 = VAL_W'(32768);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_ACC   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [ASUM_W-1:0] asum;
  } sum_t;

  function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
    clamp_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

@@ rtl/area_weighted_regrid_top.sv @@
// Area-weighted regridding engine.
// Command channel: a word is taken on a rising edge with start high and busy
// low. cmd_i selects clear, load, accumulate or read; the index and value
// ports carry the operands. Only a read answers: its word appears on
// target_value_o, no_area_o and echo_index_o for one cycle with done_o high.
// The receiver cannot hold a result off.
// What each command does before the next one can be accepted:
//   load: written at the accepting edge; out-of-range commands: nothing more,
//   accumulate: sum memory read, multiply, saturating add and write back,
//   read: memory read at the accepting edge, zero check and, unless the
//   area sum is zero, 17 restoring divider steps, one quotient bit each.
//   clear: one sum memory entry zeroed per cycle.
// A read result is shown in the cycle after its last busy cycle, busy being low.
// After reset the same clearing pass runs with busy high; the source memory
// holds no defined values until loaded.
// The sum memory is single-write, single-read with a registered read, so
// each command owns it alone until busy falls.
module area_weighted_regrid_top
  import awr_pkg::*;
#(
  parameter int unsigned TARGET_CELLS = TARGET_CELLS_DEF,
  parameter int unsigned SOURCE_CELLS = SOURCE_CELLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [TIX_W-1:0]  target_index_i,
  input  logic [SIX_W-1:0]  source_index_i,
  input  logic [VAL_W-1:0]  overlap_frac_i,
  input  logic [VAL_W-1:0]  source_value_i,
  output logic              done_o,
  output logic [VAL_W-1:0]  target_value_o,
  output logic              no_area_o,
  output logic [TIX_W-1:0]  echo_index_o
);

  localparam int unsigned TAW = $clog2(TARGET_CELLS);
  localparam int unsigned SAW = $clog2(SOURCE_CELLS);
  localparam logic [TAW-1:0] LAST_TIX = TAW'(TARGET_CELLS - 1);
  localparam int unsigned STEP_W = $clog2(VAL_W + 1);
  localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(VAL_W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLR    = 3'd1;
  localparam logic [2:0] S_ACC_MU = 3'd2;
  localparam logic [2:0] S_ACC_WR = 3'd3;
  localparam logic [2:0] S_RD_CHK = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [TAW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [TAW-1:0]    tix_q, tix_d;
  logic [TIX_W-1:0]  echo_q, echo_d;
  logic [VAL_W-1:0]  frac_q, frac_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  sum_t              sum_q, sum_d;
  logic [WSUM_W-1:0] rem_q, rem_d;
  logic [WSUM_W-1:0] dvs_q, dvs_d;
  logic [VAL_W:0]    quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              no_area_q, no_area_d;

  sum_t              sum_mem [TARGET_CELLS];
  logic [VAL_W-1:0]  src_mem [SOURCE_CELLS];
  sum_t              sum_rd_q;
  logic [VAL_W-1:0]  src_rd_q;

  logic              accept;
  cmd_e              cmd;
  logic [IDX_W-1:0]  tix_ext, six_ext;
  logic              tix_ok, six_ok;
  logic [TAW-1:0]    tix_in;
  logic [SAW-1:0]    six_in;
  logic              sum_rd_en, src_rd_en, src_we, sum_we;
  logic [TAW-1:0]    sum_waddr;
  sum_t              sum_wdata;
  logic [WSUM_W:0]   wsum_add;
  logic [ASUM_W:0]   asum_add;
  logic              div_ge;
  logic [VAL_W:0]    quo_next;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign cmd     = cmd_e'(cmd_i);
  assign tix_ext = IDX_W'(target_index_i);
  assign six_ext = IDX_W'(source_index_i);
  assign tix_ok  = tix_ext < IDX_W'(TARGET_CELLS);
  assign six_ok  = six_ext < IDX_W'(SOURCE_CELLS);
  assign tix_in  = tix_ext[TAW-1:0];
  assign six_in  = six_ext[SAW-1:0];

  assign src_we    = accept && (cmd == CMD_LOAD) && six_ok;
  assign src_rd_en = accept && (cmd == CMD_ACC);
  assign sum_rd_en = accept && ((cmd == CMD_ACC) || (cmd == CMD_READ));

  assign wsum_add = {1'b0, sum_q.wsum} + (WSUM_W + 1)'(prod_q);
  assign asum_add = {1'b0, sum_q.asum} + (ASUM_W + 1)'(frac_q);

  assign div_ge   = rem_q >= dvs_q;
  assign quo_next = {quo_q[VAL_W-1:0], div_ge};

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = tix_q;
    sum_wdata = '0;
    if (state_q == S_CLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_cnt_q;
    end else if (state_q == S_ACC_WR) begin
      sum_we         = 1'b1;
      sum_wdata.wsum = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
      sum_wdata.asum = asum_add[ASUM_W] ? '1 : asum_add[ASUM_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    tix_d     = tix_q;
    echo_d    = echo_q;
    frac_d    = frac_q;
    prod_d    = prod_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    step_d    = step_q;
    done_d    = 1'b0;
    value_d   = value_q;
    no_area_d = no_area_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tix_d  = tix_in;
          echo_d = target_index_i;
          frac_d = clamp_one(overlap_frac_i);
          case (cmd)
            CMD_CLEAR: begin
              state_d   = S_CLR;
              clr_cnt_d = '0;
            end
            CMD_LOAD: state_d = S_IDLE;
            CMD_ACC: begin
              if (tix_ok && six_ok) begin
                state_d = S_ACC_MU;
              end
            end
            CMD_READ: begin
              if (tix_ok) begin
                state_d = S_RD_CHK;
              end else begin
                done_d    = 1'b1;
                value_d   = '0;
                no_area_d = 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_TIX) begin
          state_d = S_IDLE;
        end
      end
      S_ACC_MU: begin
        prod_d  = PROD_W'(frac_q) * PROD_W'(src_rd_q);
        sum_d   = sum_rd_q;
        state_d = S_ACC_WR;
      end
      S_ACC_WR: state_d = S_IDLE;
      S_RD_CHK: begin
        if (sum_rd_q.asum == '0) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          value_d   = '0;
          no_area_d = 1'b1;
        end else begin
          state_d = S_DIV;
          rem_d   = sum_rd_q.wsum;
          dvs_d   = {sum_rd_q.asum, {(WSUM_W - ASUM_W){1'b0}}};
          quo_d   = '0;
          step_d  = DIV_FIRST;
        end
      end
      S_DIV: begin
        if (div_ge) begin
          rem_d = rem_q - dvs_q;
        end
        dvs_d  = dvs_q >> 1;
        quo_d  = quo_next;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          no_area_d = 1'b0;
          value_d   = (quo_next > {1'b0, ONE_Q15}) ? ONE_Q15 : quo_next[VAL_W-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tix_q     <= tix_d;
    echo_q    <= echo_d;
    frac_q    <= frac_d;
    prod_q    <= prod_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    value_q   <= value_d;
    no_area_q <= no_area_d;
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (sum_rd_en) begin
      sum_rd_q <= sum_mem[tix_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[six_in] <= clamp_one(source_value_i);
    end
    if (src_rd_en) begin
      src_rd_q <= src_mem[six_in];
    end
  end

  assign done_o         = done_q;
  assign target_value_o = value_q;
  assign no_area_o      = no_area_q;
  assign echo_index_o   = echo_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while busy");

  a_no_area_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && no_area_q) |-> (value_q == '0))
    else $error("no-area result carries a value");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (value_q <= ONE_Q15))
    else $error("result above one");

  a_clr_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && clr_cnt_q != LAST_TIX) |=>
      (state_q == S_CLR && clr_cnt_q == $past(clr_cnt_q) + 1'b1))
    else $error("clearing pass skipped an entry");

  a_div_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q != '0) |=>
      (state_q == S_DIV && step_q == $past(step_q) - 1'b1))
    else $error("divider left early");

endmodule
